### rtl/spnc_pkg.sv
// ----------------------------------------------------------------------------
// spnc_pkg
// Shared constants, types and the status struct of the pair nesting checker.
// ----------------------------------------------------------------------------
package spnc_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int LABEL_W     = 32;
  localparam int DEPTH_OUT_W = 7;

  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [LABEL_W-1:0] label_t;

  localparam cnt_t FULL_CNT = cnt_t'(STACK_DEPTH);

  typedef struct packed {
    logic done;
    logic found;
    logic top_match;
  } scan_res_t;

endpackage

### rtl/spnc_if.sv
// ----------------------------------------------------------------------------
// spnc_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface spnc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [spnc_pkg::LABEL_W-1:0]   label;
  logic                                  start_req;

  modport source (output valid, output label, output start_req, input ready);
  modport sink   (input valid, input label, input start_req, output ready);
endinterface

interface spnc_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  valid_so_far;
  logic                                  closed_pair;
  logic [spnc_pkg::DEPTH_OUT_W-1:0]      depth;
  logic                                  overflowed;

  modport source (output valid, output valid_so_far, output closed_pair,
                  output depth, output overflowed, input ready);
  modport sink   (input valid, input valid_so_far, input closed_pair,
                  input depth, input overflowed, output ready);
endinterface

### rtl/spnc_ram.sv
// ----------------------------------------------------------------------------
// spnc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spnc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/spnc_scan.sv
// ----------------------------------------------------------------------------
// spnc_scan
// Search engine: walks the held stack entries one per cycle through a single
// equality comparator and reports presence and whether the top matched.
// ----------------------------------------------------------------------------
module spnc_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  spnc_pkg::label_t   label,
  input  spnc_pkg::cnt_t     depth,
  input  spnc_pkg::label_t   rd_data,
  output logic               rd_en,
  output spnc_pkg::addr_t    rd_addr,
  output spnc_pkg::scan_res_t res
);

  logic           busy_r,      busy_nxt;
  spnc_pkg::cnt_t idx_r,       idx_nxt;
  logic           cmp_vld_r,   cmp_vld_nxt;
  logic           found_r,     found_nxt;
  logic           top_match_r, top_match_nxt;
  logic           eq;
  logic           finish;

  assign rd_en   = busy_r && (idx_r < depth);
  assign rd_addr = idx_r[spnc_pkg::ADDR_W-1:0];
  assign eq      = (rd_data == label);
  assign finish  = busy_r && !rd_en && !cmp_vld_r;

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    cmp_vld_nxt   = cmp_vld_r;
    found_nxt     = found_r;
    top_match_nxt = top_match_r;
    if (go) begin
      busy_nxt      = 1'b1;
      idx_nxt       = '0;
      cmp_vld_nxt   = 1'b0;
      found_nxt     = 1'b0;
      top_match_nxt = 1'b0;
    end else if (busy_r) begin
      if (rd_en) begin
        idx_nxt = idx_r + spnc_pkg::cnt_t'(1);
      end
      cmp_vld_nxt = rd_en;
      if (cmp_vld_r) begin
        found_nxt     = found_r | eq;
        top_match_nxt = eq;
      end
      if (finish) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      top_match_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      found_r     <= found_nxt;
      top_match_r <= top_match_nxt;
    end
  end

  assign res.done      = finish;
  assign res.found     = found_r;
  assign res.top_match = top_match_r;

endmodule

### rtl/stack_pair_nesting_checker_unit.sv
// The search reads the D entries held before the item, one entry per cycle,
// through the single stack RAM read port and comparator (D = 0 after a start
// request, at most STACK_DEPTH). A new item is accepted only after the current
// result commits, which can wait on output back-pressure.
// Reset: synchronous active-low; stack empty, verdict valid, overflow clear.
// ----------------------------------------------------------------------------
// stack_pair_nesting_checker_unit
// Checks pair nesting of a label stream against a bounded label stack.
// ----------------------------------------------------------------------------
module stack_pair_nesting_checker_unit (
  input  logic          clk,
  input  logic          rst_n,
  spnc_in_if.sink       in_ch,
  spnc_out_if.source    out_ch
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LAUNCH = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0]          state_r,   state_nxt;
  spnc_pkg::cnt_t      depth_r,   depth_nxt;
  logic                verdict_r, verdict_nxt;
  logic                ovf_r,     ovf_nxt;
  spnc_pkg::label_t    lab_r;
  logic                out_valid_r;
  logic                out_verdict_r;
  logic                out_closed_r;
  logic [spnc_pkg::DEPTH_OUT_W-1:0] out_depth_r;
  logic                out_ovf_r;

  logic                in_fire;
  logic                commit;
  logic                full;
  logic                ram_we;
  logic                ram_re;
  spnc_pkg::addr_t     ram_raddr;
  spnc_pkg::label_t    ram_rdata;
  spnc_pkg::scan_res_t scan_res;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign commit      = (state_r == ST_COMMIT) && (!out_valid_r || out_ch.ready);
  assign full        = (depth_r >= spnc_pkg::FULL_CNT);
  assign ram_we      = commit && !scan_res.found && !full;

  spnc_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (state_r == ST_LAUNCH),
    .label   (lab_r),
    .depth   (depth_r),
    .rd_data (ram_rdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .res     (scan_res)
  );

  spnc_ram #(
    .WIDTH (spnc_pkg::LABEL_W),
    .DEPTH (spnc_pkg::STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (depth_r[spnc_pkg::ADDR_W-1:0]),
    .wdata (lab_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    depth_nxt   = depth_r;
    verdict_nxt = verdict_r;
    ovf_nxt     = ovf_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_LAUNCH;
          if (in_ch.start_req) begin
            depth_nxt   = '0;
            verdict_nxt = 1'b1;
            ovf_nxt     = 1'b0;
          end
        end
      end
      ST_LAUNCH: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit) begin
          state_nxt = ST_IDLE;
          if (scan_res.found) begin
            depth_nxt   = depth_r - spnc_pkg::cnt_t'(1);
            verdict_nxt = verdict_r & scan_res.top_match;
          end else if (!full) begin
            depth_nxt = depth_r + spnc_pkg::cnt_t'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      depth_r     <= '0;
      verdict_r   <= 1'b1;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      depth_r   <= depth_nxt;
      verdict_r <= verdict_nxt;
      ovf_r     <= ovf_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      lab_r <= $unsigned(in_ch.label);
    end
    if (commit) begin
      out_verdict_r <= verdict_nxt;
      out_closed_r  <= scan_res.found;
      out_depth_r   <= spnc_pkg::DEPTH_OUT_W'(depth_nxt);
      out_ovf_r     <= ovf_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.valid_so_far = out_verdict_r;
  assign out_ch.closed_pair  = out_closed_r;
  assign out_ch.depth        = out_depth_r;
  assign out_ch.overflowed   = out_ovf_r;

endmodule

### rtl/spnc_chk.sv
// ----------------------------------------------------------------------------
// spnc_chk
// Port-level checks of the pair nesting checker, bound to the top level.
// ----------------------------------------------------------------------------
module spnc_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_valid_so_far,
  input logic                             out_closed_pair,
  input logic [spnc_pkg::DEPTH_OUT_W-1:0] out_depth,
  input logic                             out_overflowed
);

  localparam logic [spnc_pkg::DEPTH_OUT_W-1:0] DEPTH_LIM =
    spnc_pkg::DEPTH_OUT_W'(spnc_pkg::STACK_DEPTH);
  localparam bit WIDE_DEPTH = (spnc_pkg::STACK_DEPTH > 127);

  // A transfer moves the unit from idle into the launch state, so an input
  // transfer is never followed directly by another one.
  a_busy_after_transfer: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready
  ) else $error("input accepted in the cycle after a transfer");

  a_out_hold: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_valid_so_far, out_closed_pair, out_depth, out_overflowed})
  ) else $error("stalled result changed or dropped");

  a_depth_bound: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid |-> WIDE_DEPTH || (out_depth <= DEPTH_LIM)
  ) else $error("reported depth exceeds the stack size");

  // A closed pair pops an entry, so the stack can never be full afterwards.
  a_pop_not_full: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid && out_closed_pair |-> WIDE_DEPTH || (out_depth != DEPTH_LIM)
  ) else $error("closed pair reported with a full stack");

endmodule

bind stack_pair_nesting_checker_unit spnc_chk u_spnc_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_valid_so_far (out_ch.valid_so_far),
  .out_closed_pair  (out_ch.closed_pair),
  .out_depth        (out_ch.depth),
  .out_overflowed   (out_ch.overflowed)
);
